>>> hdl/sob_pkg.sv
// Shared types, constants and helper functions of the RGB Sobel edge block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sob_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int COUNT_W    = 27;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int PIX_W      = 24;
  localparam int ACC_W      = 12;
  localparam int SQ_W       = 21;
  localparam int TAP_W      = 4;
  localparam int STEP_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [TAP_W-1:0]     LAST_TAP       = 4'd8;
  localparam logic [STEP_W-1:0]    LAST_STEP      = 3'd7;
  localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
  localparam logic [FW_W-1:0]      WIDTH_RESET    = 11'd640;
  localparam logic [FH_W-1:0]      HEIGHT_RESET   = 16'd480;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ACC,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } sob_state_t;

  typedef struct packed {
    logic              accept;
    logic              clear;
    logic              rd_en;
    logic [TAP_W-1:0]  tap;
    logic              square;
    logic              root_en;
    logic [STEP_W-1:0] root_step;
    logic              emit;
  } sob_cmd_t;

  typedef struct packed {
    logic need_result;
    logic out_free;
  } sob_status_t;

  // Window row of a tap: 0 is the row above the centre, 2 the row below.
  function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] tap);
    logic [1:0] r;
    case (tap)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] tap);
    logic [1:0] c;
    case (tap)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] weight_x(input logic [TAP_W-1:0] tap);
    logic signed [2:0] m;
    m = (tap_row(tap) == 2'd1) ? 3'sd2 : 3'sd1;
    case (tap_col(tap))
      2'd0:    return -m;
      2'd2:    return m;
      default: return 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] weight_y(input logic [TAP_W-1:0] tap);
    logic signed [2:0] m;
    m = (tap_col(tap) == 2'd1) ? 3'sd2 : 3'sd1;
    case (tap_row(tap))
      2'd0:    return -m;
      2'd2:    return m;
      default: return 3'sd0;
    endcase
  endfunction

  // Weighted channel value; weights are only 0, +-1 and +-2.
  function automatic logic signed [ACC_W-1:0] scale(input logic [7:0] v,
                                                    input logic signed [2:0] w);
    logic signed [ACC_W-1:0] e;
    e = $signed({4'b0000, v});
    case (w)
      3'sd1:   return e;
      3'sd2:   return e <<< 1;
      -3'sd1:  return -e;
      -3'sd2:  return -(e <<< 1);
      default: return '0;
    endcase
  endfunction

endpackage

>>> hdl/sobel_edge_rgb_3x3.sv
// Channel     | handshake             | payload
// in_         | in_tvalid/in_tready   | tdata red,green,blue; tuser drain flag
// out_        | out_tvalid/out_tready | tdata red,green,blue; tlast frame end
// cfg_        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An item without a result is only written and checked; one with a result also
// takes nine reads of the single read port of the delay line, a squaring step
// and eight steps of the bitwise square root. Reset is synchronous and active
// low; the delay line needs no clearing. A result waits in the output register
// while the next item is taken; only a second result stalls until it leaves.
// Top level of the RGB Sobel edge block; depends on sob_pkg, sob_ctrl, sob_dp.
module sobel_edge_rgb_3x3 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_red, in_green, in_blue
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_red, out_green, out_blue
  output logic        out_tlast,  // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sob_pkg::CFG_DATA_W-1:0] cfg_data
);

  sob_pkg::sob_cmd_t    cmd;
  sob_pkg::sob_status_t status;

  assign cfg_ready = 1'b1;

  sob_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .status  (status),
    .cmd     (cmd)
  );

  sob_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_op    (in_tuser),
    .in_pix   (in_tdata),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pix  (out_tdata),
    .out_last (out_tlast)
  );

endmodule

>>> hdl/sob_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sob_ctrl.sv
// Sequencer of the Sobel block: walks each item through write, need check
// and, if due, tap reads, squaring, square root, output. Depends on sob_pkg.
module sob_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sob_pkg::sob_status_t status,
  output sob_pkg::sob_cmd_t    cmd
);

  sob_pkg::sob_state_t state_r, state_nxt;
  logic [sob_pkg::TAP_W-1:0]  tap_r, tap_nxt;
  logic [sob_pkg::STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sob_pkg::ST_IDLE;
      tap_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    step_nxt      = step_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.tap       = tap_r;
    cmd.root_step = step_r;
    case (state_r)
      sob_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = sob_pkg::ST_CHECK;
        end
      end
      sob_pkg::ST_CHECK: begin
        cmd.clear = 1'b1;
        tap_nxt   = '0;
        state_nxt = status.need_result ? sob_pkg::ST_READ : sob_pkg::ST_IDLE;
      end
      sob_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        if (tap_r == sob_pkg::LAST_TAP) begin
          state_nxt = sob_pkg::ST_ACC;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      sob_pkg::ST_ACC: begin
        state_nxt = sob_pkg::ST_SQUARE;
      end
      sob_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        step_nxt   = '0;
        state_nxt  = sob_pkg::ST_ROOT;
      end
      sob_pkg::ST_ROOT: begin
        cmd.root_en = 1'b1;
        if (step_r == sob_pkg::LAST_STEP) begin
          state_nxt = sob_pkg::ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      sob_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sob_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sob_pkg::ST_IDLE;
      end
    endcase
  end

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> cmd.tap <= sob_pkg::LAST_TAP)
    else $error("tap index beyond the window");
  a_no_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !cmd.rd_en)
    else $error("tap read issued before the need check");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result emitted over a pending one");
  a_emit_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !$past(cmd.accept))
    else $error("result emitted without computation");

endmodule

>>> hdl/sob_dp.sv
// Datapath of the Sobel block: configuration, delay line, frame position,
// gradient accumulation, square root and output register.
// Depends on sob_pkg and sob_ram.
module sob_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sob_pkg::sob_cmd_t                 cmd,
  output sob_pkg::sob_status_t              status,
  input  logic                              in_op,
  input  logic [sob_pkg::PIX_W-1:0]         in_pix,
  input  logic                              cfg_valid,
  input  logic [sob_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sob_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sob_pkg::PIX_W-1:0]         out_pix,
  output logic                              out_last
);

  logic [sob_pkg::FW_W-1:0]    fw_r;
  logic [sob_pkg::FH_W-1:0]    fh_r;
  logic [sob_pkg::FW_W-1:0]    w;
  logic [sob_pkg::FH_W-1:0]    h;
  logic [sob_pkg::SLOT_W-1:0]  slot_r, cur_r;
  logic [sob_pkg::COUNT_W-1:0] count_r;
  logic [sob_pkg::COL_W-1:0]   col_r;
  logic [sob_pkg::ROW_W-1:0]   row_r;
  logic                        need_r;
  logic                        acc_en_r;
  logic [sob_pkg::TAP_W-1:0]   tap_d_r;
  logic signed [sob_pkg::ACC_W-1:0] gx_r [3];
  logic signed [sob_pkg::ACC_W-1:0] gy_r [3];
  logic [sob_pkg::SQ_W-1:0]    sq_r [3];
  logic [7:0]                  n_r [3];
  logic                        out_valid_r;
  logic [sob_pkg::PIX_W-1:0]   out_pix_r;
  logic                        out_last_r;

  logic [sob_pkg::PIX_W-1:0]   rd_data;
  logic [sob_pkg::SLOT_W-1:0]  rd_addr;
  logic [sob_pkg::SLOT_W-1:0]  back;
  logic [1:0]                  ri, ci, dri, dci;
  logic [16:0]                 row_pos;
  logic [10:0]                 col_pos;
  logic                        tap_ok;
  logic                        col_end, row_end, last;
  logic [sob_pkg::PIX_W-1:0]   result;

  // Effective frame size.
  always_comb begin
    if (fw_r < 11'd2) begin
      w = 11'd2;
    end else if (fw_r > 11'(sob_pkg::MAX_WIDTH)) begin
      w = 11'(sob_pkg::MAX_WIDTH);
    end else begin
      w = fw_r;
    end
    h = (fh_r < 16'd2) ? 16'd2 : fh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= sob_pkg::WIDTH_RESET;
      fh_r <= sob_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sob_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_data[sob_pkg::FW_W-1:0];
        sob_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Distance back from the current slot to the tap being read.
  always_comb begin
    ri = sob_pkg::tap_row(cmd.tap);
    ci = sob_pkg::tap_col(cmd.tap);
    case (ri)
      2'd0:    back = {w, 1'b0};
      2'd1:    back = {1'b0, w};
      default: back = '0;
    endcase
    back = back + sob_pkg::SLOT_W'(2'd2 - ci);
    if (cur_r >= back) begin
      rd_addr = cur_r - back;
    end else begin
      rd_addr = cur_r + sob_pkg::SLOT_W'(sob_pkg::LINE_DEPTH) - back;
    end
  end

  sob_ram #(
    .WIDTH(sob_pkg::PIX_W),
    .DEPTH(sob_pkg::LINE_DEPTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (cmd.accept),
    .wr_addr(slot_r),
    .wr_data(in_op ? '0 : in_pix),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    col_end = ({1'b0, col_r} + 11'd1) >= w;
    row_end = ({1'b0, row_r} + 17'd1) >= {1'b0, h};
    last    = col_end && row_end;
    dri     = sob_pkg::tap_row(tap_d_r);
    dci     = sob_pkg::tap_col(tap_d_r);
    // Tap position plus one, so that the row above the top edge reads as zero.
    row_pos = {1'b0, row_r} + 17'(dri);
    col_pos = {1'b0, col_r} + 11'(dci);
    tap_ok  = (row_pos != '0) && (row_pos <= {1'b0, h}) &&
              (col_pos != '0) && (col_pos <= w);
  end

  // Item bookkeeping and frame position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      cur_r   <= '0;
      count_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      need_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cur_r  <= slot_r;
        slot_r <= (slot_r == sob_pkg::SLOT_W'(sob_pkg::LINE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (count_r != sob_pkg::COUNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
        need_r <= count_r > sob_pkg::COUNT_W'(w);
      end
      if (cmd.emit) begin
        if (last) begin
          count_r <= '0;
          col_r   <= '0;
          row_r   <= '0;
        end else if (col_end) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.rd_en;
    end
    tap_d_r <= cmd.tap;
  end

  // Per-channel gradient accumulation, squaring and bitwise square root.
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [7:0]                  v;
    logic signed [23:0]          gx_e, gy_e;
    logic [7:0]                  t;
    logic [15:0]                 tt;
    logic [16:0]                 nn;
    logic [8:0]                  rounded;

    always_comb begin
      v       = rd_data[8*ch +: 8];
      gx_e    = 24'(gx_r[ch]);
      gy_e    = 24'(gy_r[ch]);
      t       = n_r[ch] | (8'h80 >> cmd.root_step);
      tt      = 16'(t) * 16'(t);
      nn      = 17'(n_r[ch]) * 17'(n_r[ch]) + 17'(n_r[ch]);
      rounded = (sq_r[ch] > 21'(nn)) ? 9'(n_r[ch]) + 9'd1 : 9'(n_r[ch]);
      result[8*ch +: 8] = rounded[8] ? 8'hFF : rounded[7:0];
    end

    always_ff @(posedge clk) begin
      if (cmd.clear) begin
        gx_r[ch] <= '0;
        gy_r[ch] <= '0;
      end else if (acc_en_r && tap_ok) begin
        gx_r[ch] <= gx_r[ch] + sob_pkg::scale(v, sob_pkg::weight_x(tap_d_r));
        gy_r[ch] <= gy_r[ch] + sob_pkg::scale(v, sob_pkg::weight_y(tap_d_r));
      end
      if (cmd.square) begin
        sq_r[ch] <= 21'(gx_e * gx_e) + 21'(gy_e * gy_e);
        n_r[ch]  <= '0;
      end else if (cmd.root_en && ({5'b0, tt} <= sq_r[ch])) begin
        n_r[ch] <= t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_pix_r  <= result;
      out_last_r <= last;
    end
  end

  assign status.need_result = need_r;
  assign status.out_free    = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_pix            = out_pix_r;
  assign out_last           = out_last_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < sob_pkg::SLOT_W'(sob_pkg::LINE_DEPTH))
    else $error("write slot outside the delay line");

endmodule

>>> tb/sob_checker.sv
`timescale 1ns / 100ps
// Checker for the RGB Sobel edge block: watches the pixel, result and register
// channels, predicts every result and compares it. Depends on sob_pkg.
module sob_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sob_pkg::CFG_DATA_W-1:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;
  } edge_px_t;

  edge_px_t                    edge_q[$];
  logic [sob_pkg::PIX_W-1:0]   pixel_line[sob_pkg::LINE_DEPTH];
  logic [sob_pkg::COUNT_W-1:0] taken;
  logic [sob_pkg::COL_W-1:0]   col;
  logic [sob_pkg::ROW_W-1:0]   row;
  int                          slot;
  logic [sob_pkg::FW_W-1:0]    width_reg;
  logic [sob_pkg::FH_W-1:0]    height_reg;

  assign pending = edge_q.size();

  function automatic logic [7:0] edge_magnitude(input int unsigned s);
    int unsigned n;
    n = 0;
    for (int b = 128; b != 0; b = b >> 1)
      if ((n | b) * (n | b) <= s) n = n | b;
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t sob_checker: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Updates the model state for one accepted item and queues its result, if any.
  task automatic predict_edge(input logic drain, input logic [23:0] rgb);
    int w, h, cur, k, back, rr, cc;
    int gx[3], gy[3];
    logic [23:0] px;
    edge_px_t e;
    logic at_end;
    w = width_reg;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > sob_pkg::MAX_WIDTH) w = sob_pkg::MAX_WIDTH;
    if (h < 2) h = 2;
    cur = slot;
    k = taken;
    pixel_line[cur] = drain ? '0 : rgb;
    slot = (cur + 1) % sob_pkg::LINE_DEPTH;
    if (taken != sob_pkg::COUNT_MAX) taken++;
    if (k < w + 1) return;
    for (int c = 0; c < 3; c++) begin
      gx[c] = 0;
      gy[c] = 0;
    end
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(row) + dr;
        cc = int'(col) + dc;
        if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          back = (1 - dr) * w + (1 - dc);
          px = pixel_line[(cur + sob_pkg::LINE_DEPTH - back) % sob_pkg::LINE_DEPTH];
          for (int c = 0; c < 3; c++) begin
            gx[c] += int'(px[8*c +: 8]) * dc * ((dr == 0) ? 2 : 1);
            gy[c] += int'(px[8*c +: 8]) * dr * ((dc == 0) ? 2 : 1);
          end
        end
      end
    e.red   = edge_magnitude(gx[0] * gx[0] + gy[0] * gy[0]);
    e.green = edge_magnitude(gx[1] * gx[1] + gy[1] * gy[1]);
    e.blue  = edge_magnitude(gx[2] * gx[2] + gy[2] * gy[2]);
    at_end = (int'(row) + 1 >= h) && (int'(col) + 1 >= w);
    e.frame_last = at_end;
    edge_q.push_back(e);
    if (at_end) begin
      taken = '0;
      col = '0;
      row = '0;
    end else if (int'(col) + 1 >= w) begin
      col = '0;
      row = row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
  endtask

  initial begin
    errors = 0;
    foreach (pixel_line[i]) pixel_line[i] = '0;
  end

  always @(posedge clk) begin
    edge_px_t want;
    if (!rst_n) begin
      edge_q.delete();
      taken = '0;
      col = '0;
      row = '0;
      slot = 0;
      width_reg = sob_pkg::WIDTH_RESET;
      height_reg = sob_pkg::HEIGHT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sob_pkg::REG_FRAME_WIDTH)
          width_reg = cfg_data[sob_pkg::FW_W-1:0];
        else if (cfg_index == sob_pkg::REG_FRAME_HEIGHT)
          height_reg = cfg_data[sob_pkg::FH_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (edge_q.size() == 0) begin
          report("unexpected result", {out_tlast, out_tdata}, 0);
        end else begin
          want = edge_q.pop_front();
          if (out_tdata[7:0] !== want.red) report("red", out_tdata[7:0], want.red);
          if (out_tdata[15:8] !== want.green) report("green", out_tdata[15:8], want.green);
          if (out_tdata[23:16] !== want.blue) report("blue", out_tdata[23:16], want.blue);
          if (out_tlast !== want.frame_last)
            report("frame end flag", out_tlast, want.frame_last);
        end
      end
      if (in_tvalid && in_tready) predict_edge(in_tuser, in_tdata);
    end
  end

endmodule

>>> tb/tb_sobel_edge_rgb_3x3.sv
`timescale 1ns / 100ps
// Top of the RGB Sobel edge testbench: clock, reset, frame stimulus and verdict.
// Depends on sob_pkg, sobel_edge_rgb_3x3 and sob_checker.
module tb_sobel_edge_rgb_3x3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   ITEM_TARGET = 1500;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [23:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [23:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sob_pkg::CFG_DATA_W-1:0] cfg_data;
  int errors, pending;
  int burst_left;
  int items_sent;
  logic long_hold;

  sobel_edge_rgb_3x3 u_dut (.*);

  sob_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_sobel_edge_rgb_3x3: errors");
    $finish;
  end

  // The receiver switches at random between stall patterns.
  initial begin
    int mode;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 300)) begin
        @(negedge clk);
        if (long_hold) out_tready <= 1'b0;
        else if (mode == 0) out_tready <= 1'b1;
        else if (mode == 1) out_tready <= ($urandom_range(0, 1) == 1);
        else out_tready <= ($urandom_range(0, 9) != 0);
      end
    end
  end

  // One long hold-off on the result side while pixels keep being offered.
  initial begin
    long_hold = 1'b0;
    wait (items_sent > 200);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (800) @(negedge clk);
    long_hold = 1'b0;
  end

  task automatic write_reg(input logic [sob_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sob_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic [23:0] rgb);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= rgb;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Waits for every outstanding result, then lets the block finish its work.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    write_reg(sob_pkg::REG_FRAME_WIDTH, {5'($urandom), 11'(w)});
    write_reg(sob_pkg::REG_FRAME_HEIGHT, 16'(h));
  endtask

  // Streams one whole frame plus its flush. pattern: 0 random, 1 white,
  // 2 black/white checkerboard, 3 dark random.
  task automatic run_frame(input int w, input int h, input int pattern, input int drain_pct);
    int wc, hc;
    logic [23:0] rgb;
    wc = (w < 2) ? 2 : ((w > sob_pkg::MAX_WIDTH) ? sob_pkg::MAX_WIDTH : w);
    hc = (h < 2) ? 2 : h;
    for (int i = 0; i < wc * hc; i++) begin
      case (pattern)
        1:       rgb = '1;
        2:       rgb = (((i % wc) + (i / wc)) % 2 == 0) ? '1 : '0;
        3:       rgb = 24'($urandom) & 24'h0f0f0f;
        default: rgb = 24'($urandom);
      endcase
      // An early drain counts as a black pixel.
      if ($urandom_range(0, 99) < drain_pct) send_item(OP_DRAIN, 24'($urandom));
      else send_item(OP_PIXEL, rgb);
    end
    // Flush; a pixel offered here lies outside the frame and must be ignored.
    for (int i = 0; i <= wc; i++)
      if ($urandom_range(0, 9) == 0) send_item(OP_PIXEL, 24'($urandom));
      else send_item(OP_DRAIN, 24'($urandom));
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_PIXEL;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = sob_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    burst_left = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Directed frames: smallest size, full-scale edges, clamped registers.
    set_frame(2, 2);
    run_frame(2, 2, 2, 0);
    set_frame(0, 1);
    run_frame(0, 1, 0, 30);
    set_frame(3, 2);
    run_frame(3, 2, 1, 0);

    // A long line with clamped height, and the tallest height written then replaced.
    set_frame(300, 0);
    run_frame(300, 0, 0, 2);
    write_reg(sob_pkg::REG_FRAME_HEIGHT, 16'hffff);
    set_frame(40, 2);
    run_frame(40, 2, 3, 1);

    while (items_sent < ITEM_TARGET) begin
      int w, h;
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 8);
      if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 1);
      set_frame(w, h);
      run_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 1) * 5);
    end

    wait_idle();
    if (errors == 0) $display("tb_sobel_edge_rgb_3x3: clean");
    else $display("tb_sobel_edge_rgb_3x3: errors");
    $finish;
  end

endmodule

>>> sobel_edge_rgb_3x3.f
hdl/sob_pkg.sv
hdl/sob_ram.sv
hdl/sob_ctrl.sv
hdl/sob_dp.sv
hdl/sobel_edge_rgb_3x3.sv
tb/sob_checker.sv
tb/tb_sobel_edge_rgb_3x3.sv
